FILE: hdl/base64_stream_codec_macros.svh
// Assertion macros shared by the codec RTL.
// Depends on nothing; each file that asserts includes it.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

`ifndef SYNTH

`define B64C_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codec check failed");

`define B64C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codec check failed");

`define B64C_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("codec check failed");

`else

`define B64C_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define B64C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define B64C_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hdl/b64c_pkg.sv
// Types, codes and character tables of the Base64 stream codec.
// No dependencies; used by the interfaces and by every module of the block.
package b64c_pkg;

    localparam int GROUP_W     = 24;
    localparam int LINE_W      = 7;
    localparam int LINE_CHARS  = 72;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_AND_WRAP = 1'b1;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_NO_VALID = 2'd2;
    localparam logic [1:0] ST_BAD_PAD  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_PAD     = 8'h3d;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;

    typedef enum logic {
        JOB_ENC,
        JOB_DEC
    } job_kind_t;

    // one queued request's worth of results
    typedef struct packed {
        job_kind_t         kind;
        logic              newline;
        logic [GROUP_W-1:0] bits;
        logic [2:0]        nchar;
        logic [1:0]        npad;
        logic              has_status;
        logic [1:0]        status;
        logic              last;
    } job_t;

    typedef struct packed {
        logic direction;
        logic pad_and_wrap;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       valid;
        logic       pad;
        logic [5:0] value;
    } sextet_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = {2'b00, v} + 8'h41;
        else if (v < 6'd52)
            r = {2'b00, v} + 8'd71;
        else if (v < 6'd62)
            r = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            r = CHAR_PLUS;
        else
            r = CHAR_SLASH;
        return r;
    endfunction

    function automatic sextet_t dec_char(input logic [7:0] c);
        sextet_t r;
        r = '0;
        if (c inside {[8'h41:8'h5a]})
        begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7a]})
        begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'd71);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r.valid = 1'b1;
            r.value = 6'(c + 8'd4);
        end
        else if (c == CHAR_PLUS)
        begin
            r.valid = 1'b1;
            r.value = 6'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            r.valid = 1'b1;
            r.value = 6'd63;
        end
        else if (c == CHAR_PAD)
        begin
            r.valid = 1'b1;
            r.pad   = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/b64c_if.sv
// Channel interfaces of the codec: request, result and register write.
// Depends on b64c_pkg for the register index width.
interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source(output valid, output in_byte, output in_last, input ready);
    modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       out_last;

    modport source(output valid, output out_byte, output out_status, output out_last,
                   input ready);
    modport sink(input valid, input out_byte, input out_status, input out_last,
                 output ready);
endinterface

interface b64c_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [b64c_pkg::CFG_IDX_W-1:0]   index;
    logic                             data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/b64c_front.sv
// Front end: accepts requests, keeps the group/line state and queues one job per
// request that yields results. Depends on b64c_pkg and b64c_if.
`include "base64_stream_codec_macros.svh"

module b64c_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  b64c_pkg::cfg_t           cfg,
    b64c_in_if.sink                  request,
    input  b64c_pkg::queue_status_t  qs,
    output logic                     push,
    output b64c_pkg::job_t           job
);

    logic [b64c_pkg::GROUP_W-1:0] gb_reg, gb_next;
    logic [1:0]                   gc_reg, gc_next;
    logic [b64c_pkg::LINE_W-1:0]  lc_reg, lc_next;
    logic                         nlp_reg, nlp_next;
    logic [1:0]                   ps_reg, ps_next;
    logic                         vs_reg, vs_next;
    logic                         halt_reg, halt_next;

    logic                         accept;
    logic                         push_d;
    b64c_pkg::job_t               job_d;

    logic [b64c_pkg::GROUP_W-1:0] enc_bits;
    logic [1:0]                   enc_cnt;
    logic [b64c_pkg::LINE_W-1:0]  enc_line;
    b64c_pkg::sextet_t            sx;
    logic [b64c_pkg::GROUP_W-1:0] dec_bits;
    logic [2:0]                   dec_cnt;
    logic [1:0]                   dec_pads;
    logic                         dec_valid;
    logic                         dec_halt;
    logic [2:0]                   fill;
    logic [2:0]                   pad_sum;
    logic                         fin;
    logic                         dec_err;
    logic [1:0]                   nbytes;
    logic                         stat_en;
    logic [1:0]                   stat_code;

    assign request.ready = !qs.full;
    assign accept        = request.valid && request.ready;
    assign push          = accept && push_d;
    assign job           = job_d;

    always_comb
    begin
        gb_next   = gb_reg;
        gc_next   = gc_reg;
        lc_next   = lc_reg;
        nlp_next  = nlp_reg;
        ps_next   = ps_reg;
        vs_next   = vs_reg;
        halt_next = halt_reg;
        job_d     = '0;
        push_d    = 1'b0;

        // encode path
        enc_bits = {gb_reg[15:0], request.in_byte};
        enc_cnt  = (gc_reg == 2'd3) ? 2'd3 : gc_reg + 2'd1;
        enc_line = lc_reg + b64c_pkg::LINE_W'(4);

        // decode path: one character, then implied padding at the end
        sx        = b64c_pkg::dec_char(request.in_byte);
        dec_bits  = gb_reg;
        dec_cnt   = {1'b0, gc_reg};
        dec_pads  = ps_reg;
        dec_valid = vs_reg;
        dec_halt  = halt_reg;
        fill      = 3'd0;
        pad_sum   = 3'd0;
        dec_err   = 1'b0;
        nbytes    = 2'd0;
        stat_en   = 1'b0;
        stat_code = b64c_pkg::ST_DATA;

        if (!halt_reg && sx.valid)
        begin
            dec_valid = 1'b1;
            if (sx.pad && ps_reg != 2'd3)
                dec_pads = ps_reg + 2'd1;
            dec_bits = {gb_reg[17:0], sx.pad ? 6'd0 : sx.value};
            dec_cnt  = dec_cnt + 3'd1;
        end

        if (request.in_last && dec_valid && !halt_reg && dec_cnt != 3'd0 && dec_cnt != 3'd4)
        begin
            fill     = 3'd4 - dec_cnt;
            dec_bits = dec_bits << (int'(fill) * 6);
            pad_sum  = {1'b0, dec_pads} + fill;
            dec_pads = (pad_sum >= 3'd3) ? 2'd3 : pad_sum[1:0];
            dec_cnt  = 3'd4;
        end

        fin = !halt_reg && dec_cnt == 3'd4;
        if (fin)
        begin
            if (dec_pads == 2'd3)
            begin
                dec_err  = 1'b1;
                dec_halt = 1'b1;
            end
            else
            begin
                nbytes = 2'd3 - dec_pads;
                if (dec_pads != 2'd0)
                begin
                    dec_halt = 1'b1;
                    dec_pads = 2'd0;
                end
            end
            dec_cnt = 3'd0;
        end

        if (dec_err)
        begin
            stat_en   = 1'b1;
            stat_code = b64c_pkg::ST_BAD_PAD;
        end
        else if (request.in_last)
        begin
            if (!dec_valid)
            begin
                stat_en   = 1'b1;
                stat_code = b64c_pkg::ST_NO_VALID;
            end
            else if (nbytes == 2'd0 && !(dec_halt && dec_pads == 2'd3))
            begin
                stat_en   = 1'b1;
                stat_code = b64c_pkg::ST_END;
            end
        end

        if (!cfg.direction)
        begin
            if (enc_cnt == 2'd3 || request.in_last)
            begin
                push_d        = 1'b1;
                job_d.kind    = b64c_pkg::JOB_ENC;
                job_d.newline = nlp_reg;
                job_d.nchar   = {1'b0, enc_cnt} + 3'd1;
                job_d.npad    = (cfg.pad_and_wrap && enc_cnt != 2'd3) ? 2'd3 - enc_cnt : 2'd0;
                job_d.last    = request.in_last;
                case (enc_cnt)
                    2'd1:    job_d.bits = enc_bits << 16;
                    2'd2:    job_d.bits = enc_bits << 8;
                    default: job_d.bits = enc_bits;
                endcase
                nlp_next = 1'b0;
                if (enc_cnt == 2'd3 && cfg.pad_and_wrap)
                begin
                    // line test only after a full group of four
                    if (enc_line >= b64c_pkg::LINE_W'(b64c_pkg::LINE_CHARS))
                    begin
                        nlp_next = 1'b1;
                        lc_next  = '0;
                    end
                    else
                        lc_next = enc_line;
                end
                gb_next = '0;
                gc_next = 2'd0;
            end
            else
            begin
                gb_next = enc_bits;
                gc_next = enc_cnt;
            end
        end
        else
        begin
            push_d           = (nbytes != 2'd0) || stat_en;
            job_d.kind       = b64c_pkg::JOB_DEC;
            job_d.bits       = dec_bits;
            job_d.nchar      = {1'b0, nbytes};
            job_d.has_status = stat_en;
            job_d.status     = stat_code;
            job_d.last       = request.in_last;
            gb_next          = fin ? '0 : dec_bits;
            gc_next          = dec_cnt[1:0];
            ps_next          = dec_pads;
            vs_next          = dec_valid;
            halt_next        = dec_halt;
        end

        if (request.in_last)
        begin
            gb_next   = '0;
            gc_next   = 2'd0;
            lc_next   = '0;
            nlp_next  = 1'b0;
            ps_next   = 2'd0;
            vs_next   = 1'b0;
            halt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_reg   <= '0;
            gc_reg   <= 2'd0;
            lc_reg   <= '0;
            nlp_reg  <= 1'b0;
            ps_reg   <= 2'd0;
            vs_reg   <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (accept)
        begin
            gb_reg   <= gb_next;
            gc_reg   <= gc_next;
            lc_reg   <= lc_next;
            nlp_reg  <= nlp_next;
            ps_reg   <= ps_next;
            vs_reg   <= vs_next;
            halt_reg <= halt_next;
        end
    end

    `B64C_ASSERT_NEXT(a_clear_after_last, clk, rst_n, accept && request.in_last,
        gc_reg == 2'd0 && !halt_reg && !vs_reg && !nlp_reg && lc_reg == '0)
    `B64C_ASSERT_IMPLIES(a_enc_job_size, clk, rst_n, push && job.kind == b64c_pkg::JOB_ENC,
        job.nchar >= 3'd2 && job.nchar <= 3'd4 && !job.has_status)

endmodule

FILE: hdl/b64c_queue.sv
// Short job queue between front and back end, held in flip-flops.
// Depends on b64c_pkg for the job and status types.
`include "base64_stream_codec_macros.svh"

module b64c_queue #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  b64c_pkg::job_t           push_job,
    input  logic                     pop,
    output b64c_pkg::job_t           head,
    output b64c_pkg::queue_status_t  qs
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64c_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign head     = mem_reg[rd_ptr_reg];
    assign qs.full  = cnt_reg == CNT_W'(DEPTH);
    assign qs.empty = cnt_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    `B64C_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && cnt_reg == CNT_W'(DEPTH))

endmodule

FILE: hdl/b64c_back.sv
// Back end: walks the head job into the output register, one result per cycle
// while the receiver takes them. Depends on b64c_pkg and b64c_if.
`include "base64_stream_codec_macros.svh"

module b64c_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  b64c_pkg::job_t           head,
    input  b64c_pkg::queue_status_t  qs,
    output logic                     pop,
    b64c_out_if.source               result
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] out_status_reg, out_status_next;
    logic       out_last_reg, out_last_next;
    logic [2:0] step_reg, step_next;

    logic       load;
    logic [2:0] total;
    logic [2:0] j;
    logic [2:0] data_end;
    logic [b64c_pkg::GROUP_W-1:0] sh6;
    logic [b64c_pkg::GROUP_W-1:0] sh8;
    logic       final_step;

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.out_status = out_status_reg;
    assign result.out_last   = out_last_reg;

    assign load = !out_valid_reg || result.ready;

    always_comb
    begin
        total      = 3'(head.newline) + head.nchar + 3'(head.npad) + 3'(head.has_status);
        j          = step_reg - 3'(head.newline);
        data_end   = head.nchar + 3'(head.npad);
        sh6        = head.bits << (int'(j) * 6);
        sh8        = head.bits << (int'(j) * 8);
        final_step = step_reg == total - 3'd1;

        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        step_next       = step_reg;
        pop             = 1'b0;

        if (load)
        begin
            out_valid_next = !qs.empty;
            if (!qs.empty)
            begin
                out_status_next = b64c_pkg::ST_DATA;
                if (head.newline && step_reg == 3'd0)
                    out_byte_next = b64c_pkg::CHAR_NEWLINE;
                else if (j < head.nchar)
                    out_byte_next = (head.kind == b64c_pkg::JOB_ENC) ?
                                    b64c_pkg::enc_char(sh6[23:18]) : sh8[23:16];
                else if (j < data_end)
                    out_byte_next = b64c_pkg::CHAR_PAD;
                else
                begin
                    out_byte_next   = 8'd0;
                    out_status_next = head.status;
                end
                // a status result always closes the message
                out_last_next = final_step && (head.last || head.has_status);
                if (final_step)
                begin
                    pop       = 1'b1;
                    step_next = 3'd0;
                end
                else
                    step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    `B64C_ASSERT_IMPLIES(a_status_closes, clk, rst_n,
        out_valid_reg && out_status_reg != b64c_pkg::ST_DATA,
        out_byte_reg == 8'd0 && out_last_reg)
    `B64C_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, !qs.empty && load)

endmodule

FILE: hdl/base64_stream_codec.sv
// Base64 stream codec, top level: register port, front end, job queue, back end.
// Depends on b64c_pkg, b64c_if, b64c_front, b64c_queue and b64c_back.
//
// Usage:
//   request carries one message byte per request (in_byte, in_last marks the end);
//   result carries the produced characters or bytes (out_byte, out_status,
//   out_last on the final result of a message or on an error).
//   cfg writes direction (index 0) and pad_and_wrap (index 1); it is always
//   ready and is meant to be written while no message is in flight.
// Timing:
//   a request is taken every cycle while the job queue has room; the state
//   update for one request is done in that cycle. Each job is queued and the
//   back end moves its results from the queue head to the output register,
//   one result per cycle while the receiver takes them, so a full encode group
//   (three bytes) gives four or five results, paced by the single output port.
// Reset clears the message state, the queue and the output valid flag, and sets
// direction to encode with padding and line breaks on. When the receiver stalls
// the output register holds, the queue fills, and request.ready drops.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    b64c_in_if.sink     request,
    b64c_out_if.source  result,
    b64c_cfg_if.sink    cfg
);

    logic                     direction_reg;
    logic                     pad_wrap_reg;
    b64c_pkg::cfg_t           cfg_bus;
    b64c_pkg::queue_status_t  qs;
    b64c_pkg::job_t           push_job;
    b64c_pkg::job_t           head;
    logic                     push;
    logic                     pop;

    assign cfg.ready            = 1'b1;
    assign cfg_bus.direction    = direction_reg;
    assign cfg_bus.pad_and_wrap = pad_wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            pad_wrap_reg  <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                b64c_pkg::REG_DIRECTION:    direction_reg <= cfg.data;
                b64c_pkg::REG_PAD_AND_WRAP: pad_wrap_reg  <= cfg.data;
                default:                    ;
            endcase
        end
    end

    b64c_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .request (request),
        .qs      (qs),
        .push    (push),
        .job     (push_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qs       (qs)
    );

    b64c_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qs     (qs),
        .pop    (pop),
        .result (result)
    );

endmodule
